// ===== sv/rba_pkg.sv =====
package rba_pkg;

    localparam int NUM_BINS_DEF   = 2048;
    localparam int IMAGE_ROWS_DEF = 1024;
    localparam int IMAGE_COLS_DEF = 1024;

    localparam int SUM_W   = 41;
    localparam int SUMSQ_W = 61;
    localparam int CNT_W   = 21;
    localparam int BIDX_W  = 11;

    // register indexes
    localparam logic [2:0] REG_CENTER_ROW  = 3'd0;
    localparam logic [2:0] REG_CENTER_COL  = 3'd1;
    localparam logic [2:0] REG_MIN_LIMIT   = 3'd2;
    localparam logic [2:0] REG_MAX_LIMIT   = 3'd3;
    localparam logic [2:0] REG_DARK_OFFSET = 3'd4;
    localparam logic [2:0] REG_CCD_RADIUS  = 3'd5;
    localparam logic [2:0] REG_ZINGER      = 3'd6;
    localparam logic [2:0] REG_BIN_COUNT   = 3'd7;

    // result status codes
    localparam logic [2:0] ST_ACCUM   = 3'd0;
    localparam logic [2:0] ST_REJECT  = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd2;
    localparam logic [2:0] ST_ZINGER  = 3'd3;
    localparam logic [2:0] ST_READOUT = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SQUARE, S_DIST, S_SQRT, S_BIN,
        S_READ, S_MUL, S_DECIDE, S_WRITE, S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic square;
        logic dist_calc;
        logic sqrt_start;
        logic sqrt_step;
        logic bin;
        logic mem_read;
        logic mul;
        logic decide;
        logic write;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic is_read;
        logic early_done;
        logic sqrt_done;
        logic bin_bad;
    } dp_stat_t;

endpackage

// ===== sv/rba_datapath.sv =====
module rba_datapath #(
    parameter int NUM_BINS   = rba_pkg::NUM_BINS_DEF,
    parameter int IMAGE_ROWS = rba_pkg::IMAGE_ROWS_DEF,
    parameter int IMAGE_COLS = rba_pkg::IMAGE_COLS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rba_pkg::dp_cmd_t   cmd,
    output rba_pkg::dp_stat_t  stat,
    input  logic [15:0]        center_row,
    input  logic [15:0]        center_col,
    input  logic signed [21:0] min_limit,
    input  logic signed [21:0] max_limit,
    input  logic [19:0]        dark_offset,
    input  logic [11:0]        ccd_radius,
    input  logic [15:0]        zinger_factor,
    input  logic [11:0]        bin_count,
    input  logic [63:0]        in_data,
    output logic [143:0]       out_data
);
    import rba_pkg::*;

    localparam int AW = $clog2(NUM_BINS);
    localparam int RW = $clog2(IMAGE_ROWS) + 2;
    localparam int CW = $clog2(IMAGE_COLS) + 2;
    localparam int MAXI = (1 << BIDX_W) - 1;

    // bin memories
    logic signed [SUM_W-1:0] sum_mem [NUM_BINS];
    logic [SUMSQ_W-1:0]      sq_mem  [NUM_BINS];
    logic [CNT_W-1:0]        cnt_mem [NUM_BINS];

    logic        cmd_reg;
    logic [9:0]  row_reg, col_reg;
    logic [19:0] val_reg;
    logic [10:0] rb_reg;
    logic [AW:0] clr_reg;
    logic        ok_reg, circ_reg;

    // distance and square root
    logic signed [16:0] dr_reg, dc_reg;
    logic [31:0] dr2_reg, dc2_reg, ca_reg, cb_reg;
    logic [34:0] n_reg, r_reg;
    logic [5:0]  sq_cnt_reg;
    logic [34:0] bin_reg;
    logic [BIDX_W-1:0] bidx;

    // read-modify-write
    logic [AW-1:0] addr_reg;
    logic signed [SUM_W-1:0] s_reg;
    logic [SUMSQ_W-1:0]      q_reg;
    logic [CNT_W-1:0]        c_reg;
    logic signed [20:0]      v_reg;
    logic [40:0]             vsq_reg;
    logic signed [49:0]      lhs_a_reg;
    logic signed [57:0]      rhs_reg;

    logic [35:0] trial;
    logic [34:0] bitv;
    logic signed [42:0] s_new;
    logic [SUMSQ_W:0]   q_new;
    logic               addr_ok;

    assign bitv  = 35'd1 << {sq_cnt_reg, 1'b0};
    assign trial = {1'b0, r_reg} + {1'b0, bitv};
    assign addr_ok = ({21'd0, rb_reg} < NUM_BINS);
    assign s_new = 43'(s_reg) + 43'(v_reg);
    assign q_new = {1'b0, q_reg} + (SUMSQ_W+1)'(vsq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // memory port
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            sum_mem[clr_reg[AW-1:0]] <= '0;
            sq_mem[clr_reg[AW-1:0]]  <= '0;
            cnt_mem[clr_reg[AW-1:0]] <= '0;
        end else if (cmd.write) begin
            sum_mem[addr_reg] <= s_reg;
            sq_mem[addr_reg]  <= q_reg;
            cnt_mem[addr_reg] <= c_reg;
        end
        if (cmd.mem_read) begin
            s_reg <= sum_mem[addr_reg];
            q_reg <= sq_mem[addr_reg];
            c_reg <= cnt_mem[addr_reg];
        end else if (cmd.decide) begin
            if (cmd_reg) begin
                s_reg <= '0; q_reg <= '0; c_reg <= '0;
            end else begin
                if (s_new > 43'sh0FF_FFFF_FFFF) s_reg <= 41'sh0FF_FFFF_FFFF;
                else if (s_new < -43'sh100_0000_0000) s_reg <= -41'sh100_0000_0000;
                else s_reg <= s_new[SUM_W-1:0];
                q_reg <= q_new[SUMSQ_W] ? '1 : q_new[SUMSQ_W-1:0];
                if (c_reg != '1) c_reg <= c_reg + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= in_data[0];
            row_reg <= in_data[10:1];
            col_reg <= in_data[20:11];
            val_reg <= in_data[40:21];
            rb_reg  <= in_data[52:42];
            addr_reg <= in_data[42 +: AW];
            ok_reg <= in_data[41]
                && ($signed({2'b0, in_data[40:21]}) > min_limit)
                && ($signed({2'b0, in_data[40:21]}) < max_limit)
                && ({22'd0, in_data[10:1]} < IMAGE_ROWS)
                && ({22'd0, in_data[20:11]} < IMAGE_COLS);
            dr_reg <= $signed({3'b0, in_data[10:1], 4'b0}) - $signed({1'b0, center_row});
            dc_reg <= $signed({3'b0, in_data[20:11], 4'b0}) - $signed({1'b0, center_col});
            ca_reg <= 32'(IMAGE_ROWS) - {21'd0, in_data[10:1], 1'b0};
            cb_reg <= 32'(IMAGE_COLS) - {21'd0, in_data[20:11], 1'b0};
            v_reg  <= $signed({1'b0, in_data[40:21]}) - $signed({1'b0, dark_offset});
        end
        if (cmd.square) begin
            dr2_reg <= 32'($signed(dr_reg) * $signed(dr_reg));
            dc2_reg <= 32'($signed(dc_reg) * $signed(dc_reg));
            ca_reg  <= 32'($signed(ca_reg[RW-1:0]) * $signed(ca_reg[RW-1:0]));
            cb_reg  <= 32'($signed(cb_reg[CW-1:0]) * $signed(cb_reg[CW-1:0]));
            vsq_reg <= 41'($signed(v_reg) * $signed(v_reg));
            circ_reg <= 1'b0;
        end
        if (cmd.dist_calc) begin
            n_reg <= {1'b0, dr2_reg, 2'b0} + {1'b0, dc2_reg, 2'b0};
            circ_reg <= (ccd_radius != '0) &&
                ({1'b0, ca_reg} + {1'b0, cb_reg} >
                 {7'd0, 24'(ccd_radius) * 24'(ccd_radius), 2'b0});
        end
        // one result bit per cycle
        if (cmd.sqrt_start) begin
            r_reg <= '0;
            sq_cnt_reg <= 6'd17;
        end else if (cmd.sqrt_step) begin
            if ({1'b0, n_reg} >= trial) begin
                n_reg <= n_reg - trial[34:0];
                r_reg <= (r_reg >> 1) + bitv;
            end else begin
                r_reg <= r_reg >> 1;
            end
            sq_cnt_reg <= sq_cnt_reg - 1'b1;
        end
        if (cmd.bin) begin
            bin_reg  <= (r_reg + 35'd16) >> 5;
            addr_reg <= AW'((r_reg + 35'd16) >> 5);
        end
        if (cmd.mul) begin
            lhs_a_reg <= 50'($signed(v_reg) * $signed({8'b0, c_reg, 8'b0}));
            rhs_reg   <= 58'($signed(s_reg) * $signed({1'b0, zinger_factor}));
        end
    end

    // bin index saturated to the field width
    assign bidx = (bin_reg > 35'(MAXI)) ? BIDX_W'(MAXI) : bin_reg[BIDX_W-1:0];

    always_comb begin
        logic [2:0] st;
        logic [10:0] bi;
        st = ST_ACCUM;
        bi = bidx;
        if (cmd_reg) begin
            st = ST_READOUT; bi = rb_reg;
        end else if (!ok_reg || circ_reg) begin
            st = ST_REJECT; bi = '0;
        end else if (stat.bin_bad) begin
            st = ST_RANGE;
        end else if (zinger_factor != '0 && s_reg > 0 && 59'(lhs_a_reg) > 59'(rhs_reg)) begin
            st = ST_ZINGER;
        end
        out_data = {6'd0, 21'd0, 61'd0, 42'd0, bi, st};
        if (cmd_reg && addr_ok)
            out_data = {6'd0, c_reg, q_reg, {s_reg[SUM_W-1], s_reg}, bi, st};
    end

    assign stat.clr_done   = (clr_reg == (AW+1)'(NUM_BINS - 1));
    assign stat.is_read    = in_data[0];
    assign stat.early_done = cmd_reg ? !addr_ok : (!ok_reg || circ_reg);
    assign stat.sqrt_done  = (sq_cnt_reg == '0);
    assign stat.bin_bad    = (bin_reg >= ((bin_count < NUM_BINS) ?
                                          35'(bin_count) : 35'(NUM_BINS)));
endmodule

// ===== sv/rba_ctrl.sv =====
module rba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  logic [2:0]        status,
    input  rba_pkg::dp_stat_t stat,
    output rba_pkg::dp_cmd_t  cmd
);
    import rba_pkg::*;

    state_t state_reg, state_next;
    logic   mv_reg, mv_next;
    logic   rd_reg, rd_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            mv_reg <= 1'b0;
            rd_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
            rd_reg <= rd_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign s_tready = (state_reg == S_IDLE) && (!mv_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        rd_next = rd_reg;
        mv_next = mv_reg && !m_tready;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load = 1'b1;
                    rd_next = stat.is_read;
                    state_next = stat.is_read ? S_READ : S_SQUARE;
                end
            end
            S_SQUARE: begin cmd.square = 1'b1; state_next = S_DIST; end
            S_DIST: begin
                cmd.dist_calc = 1'b1; cmd.sqrt_start = 1'b1; state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_done) state_next = S_BIN;
            end
            S_BIN: begin
                cmd.bin = 1'b1;
                state_next = stat.early_done ? S_OUT : S_READ;
            end
            S_READ: begin cmd.mem_read = 1'b1; state_next = S_MUL; end
            S_MUL: begin
                cmd.mul = 1'b1;
                state_next = (rd_reg || !(stat.bin_bad)) ? S_DECIDE : S_OUT;
            end
            S_DECIDE: begin
                // result goes out here; write back only a valid readout or a kept pixel
                if ((rd_reg && !stat.early_done) || (!rd_reg && status == ST_ACCUM)) begin
                    cmd.decide = 1'b1;
                    cmd.write = 1'b0;
                    state_next = S_WRITE;
                end else begin
                    state_next = S_IDLE;
                end
                cmd.out_load = 1'b1;
                mv_next = 1'b1;
            end
            S_WRITE: begin cmd.write = 1'b1; state_next = S_IDLE; end
            S_OUT: begin
                cmd.out_load = 1'b1;
                mv_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result is raised only from decision states
    a_mv: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == S_DECIDE || $past(state_reg) == S_OUT))
        else $error("result raised outside decision");
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !m_tvalid) else $error("output during clear");
endmodule

// ===== sv/radial_bin_accumulator.sv =====
// One item at a time: a readout passes READ, MUL and DECIDE; a pixel passes SQUARE,
// DIST, the bit-serial square root in SQRT and BIN, then READ, MUL and DECIDE, or goes
// to OUT instead when it is rejected or its bin is out of range. A readout or a kept
// pixel then spends a WRITE state writing its bin back. No new item is taken before the
// controller is back in IDLE and the result register is free or being taken.
// Reset: synchronous active-low; a clearing pass then zeroes every bin.
module radial_bin_accumulator #(
    parameter int NUM_BINS   = rba_pkg::NUM_BINS_DEF,
    parameter int IMAGE_ROWS = rba_pkg::IMAGE_ROWS_DEF,
    parameter int IMAGE_COLS = rba_pkg::IMAGE_COLS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [21:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command, pix_row, pix_col, pix_value, mask_bit, read_bin, zero fill
    input  logic [55:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, bin_index, sum_out, sumsq_out, count_out, zero fill
    output logic [143:0] m_tdata
);
    import rba_pkg::*;

    logic [15:0] center_row_reg, center_col_reg, zinger_reg;
    logic signed [21:0] min_reg, max_reg;
    logic [19:0] dark_reg;
    logic [11:0] radius_reg, bin_count_reg;
    logic [143:0] res_data, out_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_row_reg <= '0; center_col_reg <= '0;
            min_reg <= '0; max_reg <= 22'sd65536;
            dark_reg <= '0; radius_reg <= '0; zinger_reg <= '0;
            bin_count_reg <= 12'd2048;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CENTER_ROW:  center_row_reg <= cfg_data[15:0];
                REG_CENTER_COL:  center_col_reg <= cfg_data[15:0];
                REG_MIN_LIMIT:   min_reg <= cfg_data;
                REG_MAX_LIMIT:   max_reg <= cfg_data;
                REG_DARK_OFFSET: dark_reg <= cfg_data[19:0];
                REG_CCD_RADIUS:  radius_reg <= cfg_data[11:0];
                REG_ZINGER:      zinger_reg <= cfg_data[15:0];
                REG_BIN_COUNT:   bin_count_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) out_reg <= res_data;
    end
    assign m_tdata = out_reg;

    rba_datapath #(.NUM_BINS(NUM_BINS), .IMAGE_ROWS(IMAGE_ROWS),
                   .IMAGE_COLS(IMAGE_COLS)) u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .center_row(center_row_reg), .center_col(center_col_reg),
        .min_limit(min_reg), .max_limit(max_reg), .dark_offset(dark_reg),
        .ccd_radius(radius_reg), .zinger_factor(zinger_reg),
        .bin_count(bin_count_reg), .in_data({8'd0, s_tdata}),
        .out_data(res_data)
    );

    rba_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .status(res_data[2:0]), .stat, .cmd
    );
endmodule

// ===== verif/radial_bin_accumulator_tb.sv =====
module radial_bin_accumulator_tb;
    import rba_pkg::*;

    localparam int NBINS    = 2048;
    localparam int ROWS     = 1024;
    localparam int COLS     = 1024;
    localparam int WDOG_MAX = 8000;
    localparam int DRAIN    = 40;

    typedef struct {
        bit        cmd;
        bit [9:0]  row;
        bit [9:0]  col;
        bit [19:0] val;
        bit        mask;
        bit [10:0] rbin;
    } pixel_t;

    typedef struct {
        logic [2:0]  status;
        logic [10:0] bin;
        logic [41:0] sum;
        logic [60:0] sumsq;
        logic [20:0] cnt;
    } bin_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [21:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // command, pix_row, pix_col, pix_value, mask_bit, read_bin, zero fill
    logic [55:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // status, bin_index, sum_out, sumsq_out, count_out, zero fill
    logic [143:0] m_tdata;

    radial_bin_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // shadow registers and bin memory of the predictor
    longint         cen_row, cen_col, lo_lim, hi_lim, dark, radius, zfactor, nbins_used;
    longint         acc_sum[NBINS];
    longint unsigned acc_sumsq[NBINS];
    longint unsigned acc_cnt[NBINS];

    bin_result_t expected_q[$];
    int          errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          status_seen[5];
    bit          idling = 1'b1;
    int          wdog = 0;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, t;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    // expected result of one accepted item; updates the bin memory
    function automatic bin_result_t bin_predict(pixel_t p);
        bin_result_t res;
        longint row, col, v, a, b, dr, dc, s, n, lim;
        longint unsigned d2, bin, sq;
        bit ok;
        res = '{status: ST_REJECT, bin: '0, sum: '0, sumsq: '0, cnt: '0};
        if (p.cmd) begin
            res.status = ST_READOUT;
            res.bin = p.rbin;
            res.sum = 42'(acc_sum[p.rbin]);
            res.sumsq = 61'(acc_sumsq[p.rbin]);
            res.cnt = 21'(acc_cnt[p.rbin]);
            acc_sum[p.rbin] = 0;
            acc_sumsq[p.rbin] = 0;
            acc_cnt[p.rbin] = 0;
            return res;
        end
        row = p.row;
        col = p.col;
        v = p.val;
        ok = p.mask && v > lo_lim && v < hi_lim && row < ROWS && col < COLS;
        if (ok && radius >= 1) begin
            a = ROWS - 2 * row;
            b = COLS - 2 * col;
            if (a * a + b * b > 4 * radius * radius) ok = 1'b0;
        end
        if (!ok) return res;
        dr = 16 * row - cen_row;
        dc = 16 * col - cen_col;
        d2 = dr * dr + dc * dc;
        bin = (int_sqrt(4 * d2) + 16) / 32;
        lim = nbins_used < NBINS ? nbins_used : NBINS;
        res.bin = bin > 2047 ? 11'd2047 : bin[10:0];
        if (bin >= lim) begin
            res.status = ST_RANGE;
            return res;
        end
        v = v - dark;
        s = acc_sum[bin];
        n = acc_cnt[bin];
        if (zfactor != 0 && s > 0 && v * n * 256 > s * zfactor) begin
            res.status = ST_ZINGER;
            return res;
        end
        res.status = ST_ACCUM;
        sq = v * v;
        s = s + v;
        if (s > (64'sd1 <<< 40) - 1) s = (64'sd1 <<< 40) - 1;
        if (s < -(64'sd1 <<< 40)) s = -(64'sd1 <<< 40);
        acc_sum[bin] = s;
        if ((64'd1 << 61) - 1 - acc_sumsq[bin] < sq) acc_sumsq[bin] = (64'd1 << 61) - 1;
        else acc_sumsq[bin] = acc_sumsq[bin] + sq;
        if (acc_cnt[bin] < (64'd1 << 21) - 1) acc_cnt[bin]++;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
        $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, exp);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        bin_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_checked++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transfer, status", m_tdata[2:0], 0);
            end else begin
                e = expected_q.pop_front();
                if (m_tdata[2:0] < 5) status_seen[m_tdata[2:0]]++;
                if (m_tdata[2:0] !== e.status) report_mismatch("status", m_tdata[2:0], e.status);
                if (m_tdata[13:3] !== e.bin) report_mismatch("bin_index", m_tdata[13:3], e.bin);
                if (m_tdata[55:14] !== e.sum) report_mismatch("sum_out", m_tdata[55:14], e.sum);
                if (m_tdata[116:56] !== e.sumsq)
                    report_mismatch("sumsq_out", m_tdata[116:56], e.sumsq);
                if (m_tdata[137:117] !== e.cnt)
                    report_mismatch("count_out", m_tdata[137:117], e.cnt);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog > WDOG_MAX) begin
            $display("watchdog expired, %0d results outstanding", expected_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver back-pressure in bursts
    initial begin
        @(negedge aclk);
        forever begin
            if (idling && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(negedge aclk);
        end
    end

    task automatic send_pixel(pixel_t p);
        if (idling && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {3'b0, p.rbin, p.mask, p.val, p.col, p.row, p.cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(bin_predict(p));
        n_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic pixel(int row, int col, int val, bit mask = 1'b1);
        pixel_t p;
        p = '{cmd: 1'b0, row: 10'(row), col: 10'(col), val: 20'(val), mask: mask,
              rbin: 11'($urandom)};
        send_pixel(p);
    endtask

    task automatic read_out(int bin);
        pixel_t p;
        p = '{cmd: 1'b1, row: 10'($urandom), col: 10'($urandom), val: 20'($urandom),
              mask: 1'($urandom), rbin: 11'(bin)};
        send_pixel(p);
    endtask

    // stop sending until every result is back, then let the pipeline settle
    task automatic drain();
        s_tvalid = 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [21:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_CENTER_ROW:  cen_row = data[15:0];
            REG_CENTER_COL:  cen_col = data[15:0];
            REG_MIN_LIMIT:   lo_lim = longint'($signed(data));
            REG_MAX_LIMIT:   hi_lim = longint'($signed(data));
            REG_DARK_OFFSET: dark = data[19:0];
            REG_CCD_RADIUS:  radius = data[11:0];
            REG_ZINGER:      zfactor = data[15:0];
            REG_BIN_COUNT:   nbins_used = data[11:0];
            default: ;
        endcase
    endtask

    // reset values, bin extremes, limits and mask
    task automatic test_reset_defaults();
        pixel(0, 0, 100);
        pixel(0, 0, 100, 1'b0);
        pixel(3, 4, 0);
        pixel(3, 4, 65536);
        pixel(3, 4, 1048575);
        pixel(1023, 1023, 5);
        pixel(1023, 0, 65535);
        read_out(0);
        read_out(1447);
        read_out(2047);
        drain();
    endtask

    // circle, bin range, dezinger, dark offset and negative values
    task automatic test_centered_features();
        write_reg(REG_CENTER_ROW, 22'(512 * 16));
        write_reg(REG_CENTER_COL, 22'(512 * 16));
        write_reg(REG_MIN_LIMIT, 22'h200000);
        write_reg(REG_MAX_LIMIT, 22'h100000);
        write_reg(REG_DARK_OFFSET, 22'd50);
        write_reg(REG_CCD_RADIUS, 22'd100);
        write_reg(REG_ZINGER, 22'd256);
        write_reg(REG_BIN_COUNT, 22'd10);
        pixel(512, 512, 60);
        pixel(512, 512, 1000);
        pixel(512, 512, 55);
        pixel(512, 512, 40);
        pixel(512, 520, 1048575);
        pixel(512, 530, 7);
        pixel(0, 0, 7);
        pixel(412, 512, 7);
        read_out(0);
        read_out(8);
        read_out(15);
        drain();
    endtask

    // far-off centre saturates the bin index; zero bins, smallest circle
    task automatic test_register_extremes();
        write_reg(REG_CENTER_ROW, 22'hFFFF);
        write_reg(REG_CENTER_COL, 22'hFFFF);
        write_reg(REG_BIN_COUNT, 22'h800);
        write_reg(REG_CCD_RADIUS, 22'h800);
        write_reg(REG_DARK_OFFSET, 22'hFFFFF);
        write_reg(REG_ZINGER, 22'hFFFF);
        pixel(0, 0, 9);
        pixel(1023, 1023, 9);
        drain();
        write_reg(REG_BIN_COUNT, 22'd0);
        write_reg(REG_CCD_RADIUS, 22'd1);
        pixel(512, 512, 9);
        pixel(511, 512, 9);
        pixel(1023, 1023, 9);
        read_out(2047);
        drain();
    endtask

    task automatic random_setup();
        int cr, cc;
        cr = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                       : 8192 + $urandom_range(0, 1600) - 800;
        cc = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                       : 8192 + $urandom_range(0, 1600) - 800;
        write_reg(REG_CENTER_ROW, 22'(cr));
        write_reg(REG_CENTER_COL, 22'(cc));
        write_reg(REG_MIN_LIMIT, $urandom_range(0, 1) ? 22'(-$urandom_range(0, 1048576))
                                                      : 22'($urandom_range(0, 50)));
        write_reg(REG_MAX_LIMIT, $urandom_range(0, 2) == 0 ? 22'h100000
                                                           : 22'($urandom_range(2000, 1048576)));
        write_reg(REG_DARK_OFFSET, $urandom_range(0, 3) == 0 ? 22'($urandom_range(0, 1048575))
                                                             : 22'($urandom_range(0, 300)));
        write_reg(REG_CCD_RADIUS, $urandom_range(0, 2) == 0 ? 22'd0
                                                            : 22'($urandom_range(1, 2048)));
        write_reg(REG_ZINGER, $urandom_range(0, 2) == 0 ? 22'd0
                                                        : 22'($urandom_range(1, 65535)));
        write_reg(REG_BIN_COUNT, $urandom_range(0, 3) == 0 ? 22'($urandom_range(0, 4095))
                                                           : 22'($urandom_range(16, 2048)));
    endtask

    task automatic random_pixel();
        int row, col, val;
        if ($urandom_range(0, 6) == 0) begin
            read_out($urandom_range(0, 1) ? $urandom_range(0, 120) : $urandom_range(0, 2047));
            return;
        end
        if ($urandom_range(0, 1)) begin
            row = int'((cen_row >> 4) + $urandom_range(0, 40) - 20);
            col = int'((cen_col >> 4) + $urandom_range(0, 40) - 20);
            row = row < 0 ? 0 : (row > 1023 ? 1023 : row);
            col = col < 0 ? 0 : (col > 1023 ? 1023 : col);
        end else begin
            row = $urandom_range(0, 1023);
            col = $urandom_range(0, 1023);
        end
        case ($urandom_range(0, 9))
            0, 1:    val = $urandom_range(0, 1048575);
            2:       val = $urandom_range(0, 1) ? 1048575 : 0;
            default: val = int'(dark + $urandom_range(0, 3000));
        endcase
        if (val > 1048575) val = 1048575;
        pixel(row, col, val, $urandom_range(0, 9) != 0);
    endtask

    task automatic test_random_phases(int phases, int per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            random_setup();
            repeat (per_phase) random_pixel();
            drain();
        end
    endtask

    initial begin
        cen_row = 0; cen_col = 0; lo_lim = 0; hi_lim = 65536;
        dark = 0; radius = 0; zfactor = 0; nbins_used = 2048;
        for (int i = 0; i < NBINS; i++) begin
            acc_sum[i] = 0;
            acc_sumsq[i] = 0;
            acc_cnt[i] = 0;
        end
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_centered_features();
        test_register_extremes();
        test_random_phases(6, 120);
        idling = 1'b0;
        test_random_phases(1, 150);

        $display("items sent %0d, results checked %0d across fixed and random register setups",
                 n_sent, n_checked);
        $display("status mix: accum %0d reject %0d range %0d zinger %0d readout %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
